>>> rtl/svgpn_pkg.sv
// svgpn_pkg: shared types and constants for the svg path segment normalizer
`default_nettype none

package svgpn_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int S_TDATA_W       = 200;
    localparam int S_TUSER_W       = 5;
    localparam int M_TDATA_W       = 200;
    localparam int M_TUSER_W       = 3;

    // indexes into the coordinate state vector
    localparam int NUM_PTS = 6;
    localparam int PT_CUR_X   = 0;
    localparam int PT_CUR_Y   = 1;
    localparam int PT_START_X = 2;
    localparam int PT_START_Y = 3;
    localparam int PT_CTRL_X  = 4;
    localparam int PT_CTRL_Y  = 5;

    typedef enum logic [3:0] {
        ACT_M = 4'd0,
        ACT_L = 4'd1,
        ACT_H = 4'd2,
        ACT_V = 4'd3,
        ACT_C = 4'd4,
        ACT_S = 4'd5,
        ACT_Q = 4'd6,
        ACT_T = 4'd7,
        ACT_A = 4'd8,
        ACT_Z = 4'd9
    } t_action;

    typedef enum logic [2:0] {
        SEG_MOVETO  = 3'd0,
        SEG_LINETO  = 3'd1,
        SEG_QUADTO  = 3'd2,
        SEG_CUBICTO = 3'd3,
        SEG_ARCTO   = 3'd4,
        SEG_CLOSE   = 3'd5
    } t_seg_kind;

    typedef struct packed {
        t_action                    action;
        logic                       relative;
        logic signed [FIELD_W-1:0]  arg0;
        logic signed [FIELD_W-1:0]  arg1;
        logic signed [FIELD_W-1:0]  arg2;
        logic signed [FIELD_W-1:0]  arg3;
        logic signed [FIELD_W-1:0]  end_x;
        logic signed [FIELD_W-1:0]  end_y;
        logic                       large_arc;
        logic                       sweep_dir;
    } t_cmd;

    typedef struct packed {
        t_seg_kind                  seg_kind;
        logic signed [FIELD_W-1:0]  p0x;
        logic signed [FIELD_W-1:0]  p0y;
        logic signed [FIELD_W-1:0]  p1x;
        logic signed [FIELD_W-1:0]  p1y;
        logic signed [FIELD_W-1:0]  px;
        logic signed [FIELD_W-1:0]  py;
        logic                       arc_large;
        logic                       arc_sweep;
    } t_seg;

    typedef struct packed {
        logic ctrl_valid;
        logic subpath_open;
    } t_flags;

endpackage

`default_nettype wire

>>> rtl/svg_path_segment_normalizer.sv
// svg_path_segment_normalizer: top level, input register, path state and result register
// an accepted input transaction is held in the input register, then its segment goes into the result register
// throughput: one command per cycle unless the output stalls; the current point loop closes in core logic
// unknown actions (10 to 15) are dropped and give no output transaction
// reset (i_rst_n low, synchronous) clears the path state to zero and empties both stages
`default_nettype none

module svg_path_segment_normalizer #(
    parameter int COORD_WIDTH = svgpn_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // arg0, arg1, arg2, arg3, end_x, end_y (32 each), large_arc, sweep_dir, zero pad
    input  logic [svgpn_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // action (4), relative (1)
    input  logic [svgpn_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // p0x, p0y, p1x, p1y, px, py (32 each), arc_large, arc_sweep, zero pad
    output logic [svgpn_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // seg_kind (3)
    output logic [svgpn_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
    import svgpn_pkg::*;

    t_cmd                                  r_cmd, n_cmd;
    logic                                  r_cmd_valid;
    t_seg                                  r_seg;
    logic                                  r_out_valid;
    logic [NUM_PTS-1:0][COORD_WIDTH-1:0]   r_pts, n_pts;
    t_flags                                r_flags, n_flags;
    t_seg                                  n_seg;
    logic                                  n_known;
    logic                                  s1_adv;
    logic                                  in_acc;

    always_comb begin
        n_cmd.action    = t_action'(s_axis_tuser[3:0]);
        n_cmd.relative  = s_axis_tuser[4];
        n_cmd.arg0      = s_axis_tdata[31:0];
        n_cmd.arg1      = s_axis_tdata[63:32];
        n_cmd.arg2      = s_axis_tdata[95:64];
        n_cmd.arg3      = s_axis_tdata[127:96];
        n_cmd.end_x     = s_axis_tdata[159:128];
        n_cmd.end_y     = s_axis_tdata[191:160];
        n_cmd.large_arc = s_axis_tdata[192];
        n_cmd.sweep_dir = s_axis_tdata[193];
    end

    svgpn_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .i_cmd   (r_cmd),
        .i_pts   (r_pts),
        .i_flags (r_flags),
        .o_pts   (n_pts),
        .o_flags (n_flags),
        .o_seg   (n_seg),
        .o_known (n_known)
    );

    assign s1_adv        = r_cmd_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_cmd_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // control and path state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pts       <= '0;
            r_flags     <= '0;
        end else begin
            if (in_acc) begin
                r_cmd_valid <= 1'b1;
            end else if (s1_adv) begin
                r_cmd_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= n_known;
                if (n_known) begin
                    r_pts   <= n_pts;
                    r_flags <= n_flags;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= n_cmd;
        end
        if (s1_adv) begin
            r_seg <= n_seg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_seg.seg_kind;
    assign m_axis_tdata  = {6'd0, r_seg.arc_sweep, r_seg.arc_large, r_seg.py, r_seg.px,
                            r_seg.p1y, r_seg.p1x, r_seg.p0y, r_seg.p0x};

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_seg.seg_kind <= SEG_CLOSE))
        else $error("result transaction carries an undefined segment kind");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_cmd.action == ACT_Z) |=> (!r_flags.subpath_open && !r_flags.ctrl_valid))
        else $error("close left subpath or control point marked valid");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cmd_valid |-> s_axis_tready)
        else $error("input stage empty but not ready");

    a_drop_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_cmd.action > ACT_Z) |=> (!r_out_valid && $stable(r_pts)))
        else $error("unknown action produced a result or changed state");

endmodule

`default_nettype wire

>>> rtl/svgpn_core.sv
// svgpn_core: per-command segment and next-state logic
`default_nettype none

module svgpn_core #(
    parameter int COORD_WIDTH = svgpn_pkg::COORD_WIDTH_DEF
) (
    input  svgpn_pkg::t_cmd                                  i_cmd,
    input  logic [svgpn_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0]   i_pts,
    input  svgpn_pkg::t_flags                                i_flags,
    output logic [svgpn_pkg::NUM_PTS-1:0][COORD_WIDTH-1:0]   o_pts,
    output svgpn_pkg::t_flags                                o_flags,
    output svgpn_pkg::t_seg                                  o_seg,
    output logic                                             o_known
);
    import svgpn_pkg::*;

    logic signed [COORD_WIDTH-1:0] a0, a1, a2, a3, ex_in, ey_in;
    logic signed [COORD_WIDTH-1:0] cur_x, cur_y, ctrl_x, ctrl_y;
    logic signed [COORD_WIDTH-1:0] rx, ry;
    logic signed [COORD_WIDTH-1:0] ex, ey, c0x, c0y, c1x, c1y;
    logic                          rel;
    t_seg_kind                     kind;
    logic                          fl, fs;

    assign rel    = i_cmd.relative;
    assign a0     = COORD_WIDTH'(i_cmd.arg0);
    assign a1     = COORD_WIDTH'(i_cmd.arg1);
    assign a2     = COORD_WIDTH'(i_cmd.arg2);
    assign a3     = COORD_WIDTH'(i_cmd.arg3);
    assign ex_in  = COORD_WIDTH'(i_cmd.end_x);
    assign ey_in  = COORD_WIDTH'(i_cmd.end_y);
    assign cur_x  = i_pts[PT_CUR_X];
    assign cur_y  = i_pts[PT_CUR_Y];
    assign ctrl_x = i_pts[PT_CTRL_X];
    assign ctrl_y = i_pts[PT_CTRL_Y];

    // reflection of the last control point about the current point, or the current point when none is stored
    assign rx = i_flags.ctrl_valid ? ({cur_x[COORD_WIDTH-2:0], 1'b0} - ctrl_x) : cur_x;
    assign ry = i_flags.ctrl_valid ? ({cur_y[COORD_WIDTH-2:0], 1'b0} - ctrl_y) : cur_y;

    assign o_known = (i_cmd.action <= ACT_Z);

    always_comb begin
        o_pts   = i_pts;
        o_flags = i_flags;
        kind    = SEG_MOVETO;
        c0x     = '0;
        c0y     = '0;
        c1x     = '0;
        c1y     = '0;
        fl      = 1'b0;
        fs      = 1'b0;
        ex      = rel ? ex_in + cur_x : ex_in;
        ey      = rel ? ey_in + cur_y : ey_in;
        case (i_cmd.action)
            ACT_M: begin
                kind = SEG_MOVETO;
                o_flags.ctrl_valid = 1'b0;
                if (!i_flags.subpath_open) begin
                    o_pts[PT_START_X]    = ex;
                    o_pts[PT_START_Y]    = ey;
                    o_flags.subpath_open = 1'b1;
                end
            end
            ACT_L: begin
                kind = SEG_LINETO;
                o_flags.ctrl_valid = 1'b0;
            end
            ACT_H: begin
                kind = SEG_LINETO;
                ex   = rel ? a0 + cur_x : a0;
                ey   = cur_y;
                o_flags.ctrl_valid = 1'b0;
            end
            ACT_V: begin
                kind = SEG_LINETO;
                ex   = cur_x;
                ey   = rel ? a0 + cur_y : a0;
                o_flags.ctrl_valid = 1'b0;
            end
            ACT_C: begin
                kind = SEG_CUBICTO;
                c0x  = rel ? a0 + cur_x : a0;
                c0y  = rel ? a1 + cur_y : a1;
                c1x  = rel ? a2 + cur_x : a2;
                c1y  = rel ? a3 + cur_y : a3;
                o_pts[PT_CTRL_X]   = c1x;
                o_pts[PT_CTRL_Y]   = c1y;
                o_flags.ctrl_valid = 1'b1;
            end
            ACT_S: begin
                kind = SEG_CUBICTO;
                c0x  = rx;
                c0y  = ry;
                c1x  = rel ? a2 + cur_x : a2;
                c1y  = rel ? a3 + cur_y : a3;
                o_pts[PT_CTRL_X]   = c1x;
                o_pts[PT_CTRL_Y]   = c1y;
                o_flags.ctrl_valid = 1'b1;
            end
            ACT_Q: begin
                kind = SEG_QUADTO;
                c0x  = rel ? a0 + cur_x : a0;
                c0y  = rel ? a1 + cur_y : a1;
                o_pts[PT_CTRL_X]   = c0x;
                o_pts[PT_CTRL_Y]   = c0y;
                o_flags.ctrl_valid = 1'b1;
            end
            ACT_T: begin
                kind = SEG_QUADTO;
                c0x  = rx;
                c0y  = ry;
                o_pts[PT_CTRL_X]   = rx;
                o_pts[PT_CTRL_Y]   = ry;
                o_flags.ctrl_valid = 1'b1;
            end
            ACT_A: begin
                o_flags.ctrl_valid = 1'b0;
                if (a0 == '0 || a1 == '0) begin
                    kind = SEG_LINETO;
                end else begin
                    kind = SEG_ARCTO;
                    c0x  = a0;
                    c0y  = a1;
                    c1x  = a2;
                    fl   = i_cmd.large_arc;
                    fs   = i_cmd.sweep_dir;
                end
            end
            ACT_Z: begin
                kind = SEG_CLOSE;
                ex   = i_flags.subpath_open ? i_pts[PT_START_X] : cur_x;
                ey   = i_flags.subpath_open ? i_pts[PT_START_Y] : cur_y;
                o_flags.subpath_open = 1'b0;
                o_flags.ctrl_valid   = 1'b0;
            end
            default: begin
                kind = SEG_MOVETO;
                ex   = cur_x;
                ey   = cur_y;
            end
        endcase
        o_pts[PT_CUR_X] = ex;
        o_pts[PT_CUR_Y] = ey;
    end

    always_comb begin
        o_seg.seg_kind  = kind;
        o_seg.p0x       = FIELD_W'(c0x);
        o_seg.p0y       = FIELD_W'(c0y);
        o_seg.p1x       = FIELD_W'(c1x);
        o_seg.p1y       = FIELD_W'(c1y);
        o_seg.px        = FIELD_W'(ex);
        o_seg.py        = FIELD_W'(ey);
        o_seg.arc_large = fl;
        o_seg.arc_sweep = fs;
    end

endmodule

`default_nettype wire

>>> tb/svg_path_segment_normalizer_test.sv
// svg_path_segment_normalizer_test: self-checking stream testbench with a path state tracker
`timescale 1ns / 1ps

import svgpn_pkg::*;

class path_tracker;
    logic [31:0] cur_x, cur_y, start_x, start_y, ctrl_x, ctrl_y;
    bit          ctrl_valid, subpath_open;
    t_seg        pending_segs[$];
    int unsigned errors;

    function new();
        cur_x = '0; cur_y = '0; start_x = '0; start_y = '0; ctrl_x = '0; ctrl_y = '0;
        ctrl_valid = 1'b0;
        subpath_open = 1'b0;
        errors = 0;
    endfunction

    function logic [31:0] offset(logic [31:0] v, logic [31:0] base, bit rel);
        return rel ? v + base : v;
    endfunction

    function void note_command(t_cmd c);
        logic [31:0] ex, ey, refl_x, refl_y;
        t_seg        s;
        bit          rel;
        if (c.action > ACT_Z) return;
        rel = c.relative;
        ex = offset(c.end_x, cur_x, rel);
        ey = offset(c.end_y, cur_y, rel);
        refl_x = ctrl_valid ? 2 * cur_x - ctrl_x : cur_x;
        refl_y = ctrl_valid ? 2 * cur_y - ctrl_y : cur_y;
        s = '0;
        case (c.action)
            ACT_M: begin
                s.seg_kind = SEG_MOVETO;
                ctrl_valid = 1'b0;
                if (!subpath_open) begin
                    start_x = ex;
                    start_y = ey;
                    subpath_open = 1'b1;
                end
            end
            ACT_L: begin
                s.seg_kind = SEG_LINETO;
                ctrl_valid = 1'b0;
            end
            ACT_H: begin
                s.seg_kind = SEG_LINETO;
                ex = offset(c.arg0, cur_x, rel);
                ey = cur_y;
                ctrl_valid = 1'b0;
            end
            ACT_V: begin
                s.seg_kind = SEG_LINETO;
                ex = cur_x;
                ey = offset(c.arg0, cur_y, rel);
                ctrl_valid = 1'b0;
            end
            ACT_C, ACT_S: begin
                s.seg_kind = SEG_CUBICTO;
                if (c.action == ACT_C) begin
                    s.p0x = offset(c.arg0, cur_x, rel);
                    s.p0y = offset(c.arg1, cur_y, rel);
                end else begin
                    s.p0x = refl_x;
                    s.p0y = refl_y;
                end
                s.p1x = offset(c.arg2, cur_x, rel);
                s.p1y = offset(c.arg3, cur_y, rel);
                ctrl_x = s.p1x;
                ctrl_y = s.p1y;
                ctrl_valid = 1'b1;
            end
            ACT_Q, ACT_T: begin
                s.seg_kind = SEG_QUADTO;
                if (c.action == ACT_Q) begin
                    s.p0x = offset(c.arg0, cur_x, rel);
                    s.p0y = offset(c.arg1, cur_y, rel);
                end else begin
                    s.p0x = refl_x;
                    s.p0y = refl_y;
                end
                ctrl_x = s.p0x;
                ctrl_y = s.p0y;
                ctrl_valid = 1'b1;
            end
            ACT_A: begin
                ctrl_valid = 1'b0;
                if (c.arg0 == 0 || c.arg1 == 0) begin
                    s.seg_kind = SEG_LINETO;
                end else begin
                    s.seg_kind = SEG_ARCTO;
                    s.p0x = c.arg0;
                    s.p0y = c.arg1;
                    s.p1x = c.arg2;
                    s.arc_large = c.large_arc;
                    s.arc_sweep = c.sweep_dir;
                end
            end
            default: begin
                s.seg_kind = SEG_CLOSE;
                if (subpath_open) begin
                    cur_x = start_x;
                    cur_y = start_y;
                    subpath_open = 1'b0;
                end
                ctrl_valid = 1'b0;
                ex = cur_x;
                ey = cur_y;
            end
        endcase
        cur_x = ex;
        cur_y = ey;
        s.px = ex;
        s.py = ey;
        pending_segs.push_back(s);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want) begin
            $error("%s: expected %h, got %h", name, want, seen);
            errors++;
        end
    endfunction

    function void check_segment(t_seg got);
        t_seg want;
        if (pending_segs.size() == 0) begin
            $error("segment transaction with nothing expected: kind %0d", got.seg_kind);
            errors++;
            return;
        end
        want = pending_segs.pop_front();
        compare_field("seg_kind", 32'(want.seg_kind), 32'(got.seg_kind));
        compare_field("p0x", want.p0x, got.p0x);
        compare_field("p0y", want.p0y, got.p0y);
        compare_field("p1x", want.p1x, got.p1x);
        compare_field("p1y", want.p1y, got.p1y);
        compare_field("px", want.px, got.px);
        compare_field("py", want.py, got.py);
        compare_field("arc_large", 32'(want.arc_large), 32'(got.arc_large));
        compare_field("arc_sweep", 32'(want.arc_sweep), 32'(got.arc_sweep));
    endfunction
endclass

module svg_path_segment_normalizer_test;

    localparam int          RANDOM_ITEMS = 400;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 80;
    localparam logic [3:0]  ACT_SPARE_LO = 4'd10;
    localparam logic [3:0]  ACT_SPARE_HI = 4'd15;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    path_tracker            book = new();
    t_cmd                   offered_cmd = '0;
    bit                     tx_calm = 1'b0;
    int unsigned            segs_seen = 0;
    int unsigned            idle_cycles = 0;

    svg_path_segment_normalizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3, 4: return $urandom;
            default: return (($urandom_range(0, 400) - 200) << 16) + $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic t_cmd make_cmd(logic [3:0] act, bit rel,
                                      logic [31:0] a0, logic [31:0] a1,
                                      logic [31:0] a2, logic [31:0] a3,
                                      logic [31:0] ex, logic [31:0] ey, bit fl, bit fs);
        t_cmd c;
        c.action = t_action'(act);
        c.relative = rel;
        c.arg0 = a0;
        c.arg1 = a1;
        c.arg2 = a2;
        c.arg3 = a3;
        c.end_x = ex;
        c.end_y = ey;
        c.large_arc = fl;
        c.sweep_dir = fs;
        return c;
    endfunction

    function automatic t_cmd random_cmd(logic [3:0] act);
        t_cmd c;
        c = make_cmd(act, 1'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (c.action == ACT_A && $urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1) != 0) c.arg0 = '0;
            else c.arg1 = '0;
        end
        return c;
    endfunction

    task automatic send_command(input t_cmd c);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, c.sweep_dir, c.large_arc, c.end_y, c.end_x,
                         c.arg3, c.arg2, c.arg1, c.arg0};
        s_axis_tuser <= {c.relative, c.action};
        offered_cmd <= c;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // transaction monitors on both sides
    always @(posedge i_clk) begin
        t_seg got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) book.note_command(offered_cmd);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.seg_kind = t_seg_kind'(m_axis_tuser);
            got.p0x = m_axis_tdata[31:0];
            got.p0y = m_axis_tdata[63:32];
            got.p1x = m_axis_tdata[95:64];
            got.p1y = m_axis_tdata[127:96];
            got.px = m_axis_tdata[159:128];
            got.py = m_axis_tdata[191:160];
            got.arc_large = m_axis_tdata[192];
            got.arc_sweep = m_axis_tdata[193];
            book.check_segment(got);
            segs_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("svg_path_segment_normalizer: mismatch");
        $finish;
    end

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int unsigned gap;
        bit          calm;
        bit          held;
        calm = 1'b0;
        held = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && segs_seen >= 150) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 39) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int unsigned sent;
        int unsigned n;
        logic [3:0]  raw;
        t_cmd        c;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // close and smooth quad with no subpath and no stored control point
        send_command(make_cmd(ACT_Z, 1, 0, 0, 0, 0, 32'h1234_0000, 32'h5678_0000, 0, 0));
        send_command(make_cmd(ACT_T, 0, 0, 0, 0, 0, 32'h0003_0000, 32'hfffd_0000, 0, 0));
        send_command(make_cmd(ACT_M, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1, 1));
        // second moveto keeps the first subpath start, relative add wraps
        send_command(make_cmd(ACT_M, 1, 0, 0, 0, 0, 32'h0000_0001, 32'hffff_ffff, 0, 0));
        send_command(make_cmd(ACT_L, 1, 0, 0, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 0, 0));
        send_command(make_cmd(ACT_H, 1, 32'h8000_0000, 0, 0, 0, 32'h1111_1111, 0, 0, 0));
        send_command(make_cmd(ACT_V, 0, 32'h7fff_ffff, 0, 0, 0, 0, 32'h2222_2222, 0, 0));
        send_command(make_cmd(ACT_S, 0, 0, 0, 32'h0010_0000, 32'h0020_0000,
                              32'h0030_0000, 32'h0040_0000, 0, 0));
        send_command(make_cmd(ACT_C, 1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                              32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 1, 1));
        send_command(make_cmd(ACT_S, 1, 32'hdead_beef, 0, 32'h0001_8000, 32'hfffe_8000,
                              32'h0005_0000, 32'h0006_0000, 0, 0));
        send_command(make_cmd(ACT_T, 0, 0, 0, 0, 0, 32'hfff0_0000, 32'h0010_0000, 0, 0));
        send_command(make_cmd(ACT_Q, 1, 32'h0002_0000, 32'hfffe_0000, 0, 0,
                              32'h0004_0000, 32'h0001_0000, 0, 0));
        send_command(make_cmd(ACT_T, 1, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0));
        send_command(make_cmd(ACT_S, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                              32'h0000_0000, 32'h0000_0000, 0, 0));
        send_command(make_cmd(ACT_A, 0, 32'h0000_0000, 32'h0005_0000, 32'h002d_0000, 0,
                              32'h0007_0000, 32'h0008_0000, 1, 1));
        send_command(make_cmd(ACT_A, 1, 32'h0005_0000, 32'h0000_0000, 32'h002d_0000, 0,
                              32'h0001_0000, 32'h0002_0000, 1, 0));
        send_command(make_cmd(ACT_A, 1, 32'hfffb_0000, 32'h8000_0000, 32'hffa6_0000, 0,
                              32'hffff_0000, 32'h0003_0000, 1, 1));
        send_command(make_cmd(ACT_A, 0, 32'h7fff_ffff, 32'h0001_0000, 32'h0000_0000, 0,
                              32'h0009_0000, 32'hfff7_0000, 0, 1));
        send_command(make_cmd(ACT_SPARE_LO, 1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1));
        send_command(make_cmd(ACT_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(ACT_Z, 0, 0, 0, 0, 0, 32'h0bad_0000, 32'h0bad_0000, 1, 1));
        send_command(make_cmd(ACT_Z, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(ACT_M, 1, 0, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 0, 0));
        send_command(make_cmd(ACT_L, 0, 0, 0, 0, 0, 32'h0100_0000, 32'h0200_0000, 0, 0));
        send_command(make_cmd(ACT_Z, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        // random subpaths with random content, plus stray commands
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 6) == 0) begin
                raw = 4'($urandom_range(0, 15));
                c = random_cmd(raw);
                send_command(c);
                if (c.action <= ACT_Z) sent++;
            end else begin
                send_command(random_cmd(ACT_M));
                sent++;
                n = $urandom_range(1, 8);
                repeat (n) begin
                    send_command(random_cmd(4'($urandom_range(ACT_L, ACT_A))));
                    sent++;
                end
                if ($urandom_range(0, 2) != 0) begin
                    send_command(random_cmd(ACT_Z));
                    sent++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (book.pending_segs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("svg_path_segment_normalizer: match");
        end else begin
            $display("svg_path_segment_normalizer: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/svgpn_pkg.sv
rtl/svgpn_core.sv
rtl/svg_path_segment_normalizer.sv
tb/svg_path_segment_normalizer_test.sv
